// ===== src/nets_pkg.sv =====
// package: widths, constants, codes and state type of the next event time scheduler
`timescale 1ns / 1ps
`default_nettype none
package nets_pkg;

   localparam int TIME_W    = 64;
   localparam int FREQ_W    = 32;
   localparam int OP_W      = 2;
   localparam int STEPS_W   = FREQ_W + 1;
   localparam int NS_W      = 30;
   localparam int PROD_W    = NS_W + STEPS_W;
   localparam int NUM_W     = 62;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam int MUL_STEPS = NS_W;
   localparam int DIV_STEPS = NUM_W;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS);
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [NS_W-1:0]   NS_FACTOR     = 30'd1000000000;
   localparam logic [TIME_W-1:0] NS_PER_SECOND = 64'd1000000000;

   typedef enum logic [OP_W-1:0] {
      OP_RESTART   = 2'd0,
      OP_ARM       = 2'd1,
      OP_LATCH     = 2'd2,
      OP_RECOMPUTE = 2'd3
   } op_type;

   typedef enum logic {
      CSR_PERIOD = 1'b0,
      CSR_FREQ   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRAP,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic mul_start;
      logic div_start;
      logic load_rsp;
   } ctrl_type;

endpackage
`default_nettype wire

// ===== src/nets_req_if.sv =====
// interface: request channel carrying op and current time
`timescale 1ns / 1ps
`default_nettype none
interface nets_req_if
   import nets_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [TIME_W-1:0] now_ns;

   modport source (output valid, output op, output now_ns, input ready);
   modport sink   (input valid, input op, input now_ns, output ready);
endinterface
`default_nettype wire

// ===== src/nets_rsp_if.sv =====
// interface: response channel carrying the next event time and flags
`timescale 1ns / 1ps
`default_nettype none
interface nets_rsp_if
   import nets_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] next_event_ns;
   logic              updated;
   logic              out_of_range;

   modport source (output valid, output next_event_ns, output updated, output out_of_range,
                   input ready);
   modport sink   (input valid, input next_event_ns, input updated, input out_of_range,
                   output ready);
endinterface
`default_nettype wire

// ===== src/nets_csr.sv =====
// register file: period and frequency settings behind an apb-style port
`timescale 1ns / 1ps
`default_nettype none
module nets_csr
   import nets_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready,
   output      logic [TIME_W-1:0]     period_ns,
   output      logic [FREQ_W-1:0]     freq_hz
);

   logic [TIME_W-1:0] period_ff, period_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   csr_index_type     index;
   logic              wr_en;

   assign index  = csr_index_type'(paddr[CSR_ADDR_W-1]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      period_in = period_ff;
      freq_in   = freq_ff;
      if (wr_en) begin
         unique case (index)
            CSR_PERIOD: begin
               period_in = pwdata;
               freq_in   = '0;
            end
            CSR_FREQ: begin
               freq_in   = pwdata[FREQ_W-1:0];
               period_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_PERIOD: prdata = period_ff;
         CSR_FREQ:   prdata = {{(CSR_DATA_W-FREQ_W){1'b0}}, freq_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         freq_ff   <= '0;
      end else begin
         period_ff <= period_in;
         freq_ff   <= freq_in;
      end
   end

   assign period_ns = period_ff;
   assign freq_hz   = freq_ff;

endmodule
`default_nettype wire

// ===== src/nets_smul.sv =====
// bit-serial shift-add multiplier: one second in ns times a step count
`timescale 1ns / 1ps
`default_nettype none
module nets_smul
   import nets_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [STEPS_W-1:0] steps,
   output      logic               done,
   output      logic [PROD_W-1:0]  product
);

   logic [STEPS_W-1:0]   mcand_ff, mcand_in;
   logic [STEPS_W-1:0]   hi_ff, hi_in;
   logic [NS_W-1:0]      lo_ff, lo_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [STEPS_W:0]     sum;

   always_comb begin
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         mcand_in = steps;
         hi_in    = '0;
         lo_in    = NS_FACTOR;
         cnt_in   = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         hi_in  = sum[STEPS_W:1];
         lo_in  = {sum[0], lo_ff[NS_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule
`default_nettype wire

// ===== src/nets_sdiv.sv =====
// bit-serial restoring divider: one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module nets_sdiv
   import nets_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  numer,
   input  wire logic [FREQ_W-1:0] denom,
   output      logic              done,
   output      logic [NUM_W-1:0]  quot
);

   logic [NUM_W-1:0]     num_ff, num_in;
   logic [FREQ_W-1:0]    rem_ff, rem_in;
   logic [FREQ_W-1:0]    den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [FREQ_W:0]      trial;
   logic [FREQ_W+1:0]    diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      ge      = !diff[FREQ_W+1];
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule
`default_nettype wire

// ===== src/next_event_time_scheduler.sv =====
// top level: next clock edge time in period or frequency mode
//
//   channel   direction  handshake              payload
//   req_chan  in         valid/ready            op, now_ns
//   rsp_chan  out        valid/ready            next_event_ns, updated, out_of_range
//   apb       in         psel/penable, pready=1 period_ns @ 0x0, freq_hz @ 0x8
//
// one item at a time; arm, an unarmed latch, period mode and the error case go straight
// to finish; in frequency mode a restart, recompute or armed latch runs a wrap check,
// a 30-step bit-serial multiply by 1e9, then a 62-step restoring divide by the frequency
// reset is synchronous; it clears settings, tick counter, second base, arm and next time
// a result held in the output register does not stop the next request from being taken
`timescale 1ns / 1ps
`default_nettype none
module next_event_time_scheduler
   import nets_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   nets_req_if.sink                   req_chan,
   nets_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready
);

   state_type          state_ff, state_in;
   ctrl_type           ctrl;
   logic               armed_ff, armed_in;
   logic [FREQ_W-1:0]  tick_ff, tick_in;
   logic [TIME_W-1:0]  base_ff, base_in;
   logic [TIME_W-1:0]  next_time_ff, next_time_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               attempt_ff, attempt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]  rsp_next_ff, rsp_next_in;
   logic               rsp_upd_ff, rsp_upd_in;
   logic               rsp_err_ff, rsp_err_in;

   logic [TIME_W-1:0]  period_ns;
   logic [FREQ_W-1:0]  freq_hz;
   logic               accept;
   logic               attempt_now;
   logic               freq_mode;
   logic               rsp_free;
   logic               wrap;
   logic [STEPS_W-1:0] steps;
   logic               mul_done;
   logic [PROD_W-1:0]  product;
   logic               div_done;
   logic [NUM_W-1:0]   quot;
   logic [TIME_W-1:0]  result_time;
   logic               result_upd;
   logic               result_err;
   op_type             op;

   nets_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .period_ns (period_ns),
      .freq_hz   (freq_hz)
   );

   nets_smul u_smul (
      .clock   (clock),
      .reset   (reset),
      .start   (ctrl.mul_start),
      .steps   (steps),
      .done    (mul_done),
      .product (product)
   );

   nets_sdiv u_sdiv (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .numer (product[NUM_W-1:0]),
      .denom (freq_hz),
      .done  (div_done),
      .quot  (quot)
   );

   assign op             = op_type'(req_chan.op);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign freq_mode      = (period_ns == '0) && (freq_hz != '0);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign wrap           = (tick_ff == freq_hz);
   assign steps          = wrap ? STEPS_W'(1) : ({1'b0, tick_ff} + STEPS_W'(1));

   always_comb begin
      unique case (op)
         OP_RESTART:   attempt_now = 1'b1;
         OP_ARM:       attempt_now = 1'b0;
         OP_LATCH:     attempt_now = armed_ff;
         OP_RECOMPUTE: attempt_now = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (attempt_now && freq_mode) ? ST_WRAP : ST_FINISH;
            end
         end
         ST_WRAP:   state_in = ST_MUL;
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_WRAP:   ctrl.mul_start = 1'b1;
         ST_MUL:    ctrl.div_start = mul_done;
         ST_FINISH: ctrl.load_rsp  = rsp_free;
         default:   ctrl = '0;
      endcase
   end

   // result of a finished item
   always_comb begin
      result_time = next_time_ff;
      result_upd  = 1'b0;
      result_err  = 1'b0;
      if (attempt_ff) begin
         priority if (period_ns != '0) begin
            result_time = now_ff + period_ns;
            result_upd  = 1'b1;
         end else if (freq_hz != '0) begin
            result_time = base_ff + {{(TIME_W-NUM_W){1'b0}}, quot};
            result_upd  = 1'b1;
         end else begin
            result_err  = 1'b1;
         end
      end
   end

   always_comb begin
      armed_in     = armed_ff;
      tick_in      = tick_ff;
      base_in      = base_ff;
      now_in       = now_ff;
      attempt_in   = attempt_ff;
      next_time_in = next_time_ff;
      rsp_next_in  = rsp_next_ff;
      rsp_upd_in   = rsp_upd_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (accept) begin
         now_in     = req_chan.now_ns;
         attempt_in = attempt_now;
         unique case (op)
            OP_RESTART: begin
               base_in = '0;
               tick_in = '0;
            end
            OP_ARM:       armed_in = 1'b1;
            OP_LATCH: begin
               if (armed_ff) begin
                  armed_in = 1'b0;
                  tick_in  = tick_ff + 1'b1;
               end
            end
            OP_RECOMPUTE: attempt_in = 1'b1;
         endcase
      end
      if ((state_ff == ST_WRAP) && wrap) begin
         tick_in = '0;
         base_in = base_ff + NS_PER_SECOND;
      end
      if (ctrl.load_rsp) begin
         next_time_in = result_time;
         rsp_next_in  = result_time;
         rsp_upd_in   = result_upd;
         rsp_err_in   = result_err;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         armed_ff     <= 1'b0;
         tick_ff      <= '0;
         base_ff      <= '0;
         next_time_ff <= '0;
         attempt_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         tick_ff      <= tick_in;
         base_ff      <= base_in;
         next_time_ff <= next_time_in;
         attempt_ff   <= attempt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      rsp_next_ff <= rsp_next_in;
      rsp_upd_ff  <= rsp_upd_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.next_event_ns = rsp_next_ff;
   assign rsp_chan.updated       = rsp_upd_ff;
   assign rsp_chan.out_of_range  = rsp_err_ff;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// testbench: next event time scheduler checked against its own predictor under random idling
`timescale 1ns / 1ps
`default_nettype none
module tb
   import nets_pkg::*;
();

   typedef struct packed {
      logic [TIME_W-1:0] next_event_ns;
      logic              updated;
      logic              out_of_range;
   } sched_result_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   nets_req_if req_chan ();
   nets_rsp_if rsp_chan ();

   next_event_time_scheduler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor state
   logic [TIME_W-1:0] sched_period;
   logic [FREQ_W-1:0] sched_freq;
   logic [TIME_W-1:0] sched_base;
   logic [FREQ_W-1:0] sched_ticks;
   logic              sched_armed;
   logic [TIME_W-1:0] sched_next;

   sched_result_type pending_edges[$];
   sched_result_type want_edge;
   int unsigned      mismatches;
   int unsigned      req_idle_pct;
   int unsigned      rsp_stall_pct;
   int unsigned      rsp_hold_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic sched_result_type schedule_edge(op_type op, logic [TIME_W-1:0] now);
      sched_result_type r;
      logic          attempt;
      logic [TIME_W-1:0] steps;
      r = '0;
      attempt = 1'b0;
      case (op)
         OP_RESTART: begin
            sched_base = '0;
            sched_ticks = '0;
            attempt = 1'b1;
         end
         OP_ARM: sched_armed = 1'b1;
         OP_LATCH: begin
            if (sched_armed) begin
               sched_armed = 1'b0;
               sched_ticks = sched_ticks + 1'b1;
               attempt = 1'b1;
            end
         end
         default: attempt = 1'b1;
      endcase
      if (attempt) begin
         if (sched_period != '0) begin
            sched_next = now + sched_period;
            r.updated = 1'b1;
         end else if (sched_freq != '0) begin
            if (sched_ticks == sched_freq) begin
               sched_ticks = '0;
               sched_base = sched_base + NS_PER_SECOND;
            end
            steps = {32'd0, sched_ticks} + 64'd1;
            sched_next = sched_base + (NS_PER_SECOND * steps) / {32'd0, sched_freq};
            r.updated = 1'b1;
         end else begin
            r.out_of_range = 1'b1;
         end
      end
      r.next_event_ns = sched_next;
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) return '0;
      if (pick < 16) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_edges.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_chan.next_event_ns, '0);
         end else begin
            want_edge = pending_edges.pop_front();
            if (rsp_chan.next_event_ns !== want_edge.next_event_ns)
               report_mismatch("next_event_ns", rsp_chan.next_event_ns,
                               want_edge.next_event_ns);
            if (rsp_chan.updated !== want_edge.updated)
               report_mismatch("updated", 64'(rsp_chan.updated), 64'(want_edge.updated));
            if (rsp_chan.out_of_range !== want_edge.out_of_range)
               report_mismatch("out_of_range", 64'(rsp_chan.out_of_range),
                               64'(want_edge.out_of_range));
         end
      end
   end

   // result receiver with random stalls and long hold-offs
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left != 0) begin
            rsp_chan.ready = 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_chan.ready = !(rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   task automatic send_item(input op_type op, input logic [TIME_W-1:0] now);
      int unsigned gap;
      gap = 0;
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct)
         gap = ($urandom_range(15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.op = op;
      req_chan.now_ns = now;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_edges.push_back(schedule_edge(op, now));
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      drain();
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 3'b000};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == CSR_PERIOD) begin
         sched_period = value;
         sched_freq = '0;
      end else begin
         sched_freq = value[FREQ_W-1:0];
         sched_period = '0;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic csr_read(input csr_index_type idx);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = {idx, 3'b000};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == CSR_PERIOD) begin
         if (prdata !== sched_period) report_mismatch("period_ns read", prdata, sched_period);
      end else if (prdata[FREQ_W-1:0] !== sched_freq) begin
         report_mismatch("freq_hz read", 64'(prdata[FREQ_W-1:0]), 64'(sched_freq));
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic test_error_case();
      send_item(OP_RECOMPUTE, '0);
      send_item(OP_RESTART, '1);
      send_item(OP_LATCH, 64'd5);
      send_item(OP_ARM, 64'd7);
      send_item(OP_LATCH, 64'd9);
      drain();
   endtask

   task automatic test_config_regs();
      csr_write(CSR_PERIOD, '1);
      csr_read(CSR_PERIOD);
      csr_read(CSR_FREQ);
      csr_write(CSR_FREQ, '1);
      csr_read(CSR_PERIOD);
      csr_read(CSR_FREQ);
   endtask

   task automatic test_period_mode();
      csr_write(CSR_PERIOD, '1);
      send_item(OP_RECOMPUTE, '1);
      send_item(OP_RESTART, '0);
      send_item(OP_ARM, 64'd1);
      send_item(OP_LATCH, 64'h8000_0000_0000_0000);
      csr_write(CSR_PERIOD, 64'd1);
      send_item(OP_RECOMPUTE, '1);
      drain();
   endtask

   task automatic test_frequency_mode();
      csr_write(CSR_FREQ, 64'd1);
      send_item(OP_RESTART, 64'd123);
      send_item(OP_ARM, '0);
      send_item(OP_LATCH, '1);
      send_item(OP_RECOMPUTE, 64'd55);
      csr_write(CSR_FREQ, 64'hFFFF_FFFF);
      send_item(OP_RESTART, '0);
      send_item(OP_ARM, '0);
      send_item(OP_LATCH, '0);
      send_item(OP_RECOMPUTE, '1);
      drain();
   endtask

   task automatic test_counter_past_freq();
      csr_write(CSR_FREQ, 64'd5);
      send_item(OP_RESTART, '0);
      send_item(OP_ARM, '0);
      send_item(OP_LATCH, '0);
      send_item(OP_ARM, '0);
      send_item(OP_LATCH, '0);
      csr_write(CSR_FREQ, 64'd1);
      send_item(OP_RECOMPUTE, '0);
      send_item(OP_ARM, '0);
      send_item(OP_LATCH, '0);
      drain();
   endtask

   task automatic random_config();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40)      csr_write(CSR_FREQ, 64'($urandom_range(1, 8)));
      else if (pick < 55) csr_write(CSR_FREQ, {$urandom, $urandom});
      else if (pick < 70) csr_write(CSR_PERIOD, 64'($urandom_range(1, 1000)));
      else if (pick < 90) csr_write(CSR_PERIOD, {$urandom, $urandom});
      else if (pick < 95) csr_write(CSR_PERIOD, '0);
      else                csr_write(CSR_FREQ, '0);
   endtask

   task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned n_items);
      int unsigned sent;
      int unsigned pick;
      sent = 0;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (sent < n_items) begin
         if (sent % 25 == 0) random_config();
         pick = $urandom_range(99);
         if (pick < 65) begin
            send_item(OP_ARM, rand_time());
            send_item(OP_LATCH, rand_time());
            sent += 2;
         end else begin
            if (pick < 77)      send_item(OP_RESTART, rand_time());
            else if (pick < 89) send_item(OP_RECOMPUTE, rand_time());
            else if (pick < 95) send_item(OP_LATCH, rand_time());
            else                send_item(OP_ARM, rand_time());
            sent++;
         end
      end
      drain();
   endtask

   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      csr_write(CSR_PERIOD, 64'd3);
      rsp_hold_left = 200;
      repeat (12) send_item(OP_RECOMPUTE, rand_time());
      drain();
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.op = OP_RESTART;
      req_chan.now_ns = '0;
      mismatches = 0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 0;
      sched_period = '0;
      sched_freq = '0;
      sched_base = '0;
      sched_ticks = '0;
      sched_armed = 1'b0;
      sched_next = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_error_case();
      test_config_regs();
      test_period_mode();
      test_frequency_mode();
      test_counter_past_freq();
      test_random(0, 0, 100);
      test_random(46, 0, 100);
      test_random(0, 46, 100);
      test_random(10, 10, 100);
      test_backpressure();

      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
